// ===== design/gn3_pkg.sv =====
// ----------------------------------------------------------------------------
// gn3_pkg
// Shared constants and the permutation table for the 3-D gradient noise block.
// ----------------------------------------------------------------------------
`default_nettype none

package gn3_pkg;

  localparam int IN_W     = 24;
  localparam int OUT_W    = 18;
  localparam int OUT_FRAC = 16;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sh1FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 18'sh20000;

  // pipeline depths of the sub-units
  localparam int FADE_LAT = 9;
  localparam int HASH_LAT = 4;
  localparam int LERP_LAT = 3;

  // gradient codes that take the x/y pair
  localparam logic [3:0] GRAD_XY_POS = 4'd12;
  localparam logic [3:0] GRAD_XY_NEG = 4'd13;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  function automatic logic [7:0] perm(input logic [7:0] idx);
    return PERM_ROM[idx];
  endfunction

endpackage

`default_nettype wire

// ===== design/gradient_noise_3d.sv =====
// ----------------------------------------------------------------------------
// gradient_noise_3d
// Improved 3-D gradient noise: one point in, one noise value out, pipelined.
// ----------------------------------------------------------------------------
// Pipeline: input split, 9-stage fade, three 3-stage lerp levels, output
//   scaling; hashing runs alongside fade.
// Throughput: one request per cycle; the whole pipeline holds while the
//   result register waits on noise_ready.
// Reset: clears the stage valid bits only; no clearing pass.
`default_nettype none

module gradient_noise_3d #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pt_valid,
  output logic                                pt_ready,
  input  logic signed [gn3_pkg::IN_W-1:0]     x_coord,
  input  logic signed [gn3_pkg::IN_W-1:0]     y_coord,
  input  logic signed [gn3_pkg::IN_W-1:0]     z_coord,
  output logic                                noise_valid,
  input  logic                                noise_ready,
  output logic signed [gn3_pkg::OUT_W-1:0]    noise_value
);

  localparam int F      = FRAC_BITS;
  localparam int LAT    = 2 + gn3_pkg::FADE_LAT + 3 * gn3_pkg::LERP_LAT;
  localparam int PT_DLY = gn3_pkg::FADE_LAT - gn3_pkg::HASH_LAT;
  localparam int YD     = gn3_pkg::LERP_LAT;
  localparam int ZD     = 2 * gn3_pkg::LERP_LAT;
  localparam int SW     = gn3_pkg::OUT_W + 2;

  typedef struct packed {
    logic [7:0]   cx;
    logic [7:0]   cy;
    logic [7:0]   cz;
    logic [F-1:0] dx;
    logic [F-1:0] dy;
    logic [F-1:0] dz;
  } point_t;

  logic                  en;
  logic [LAT-1:0]        vld;
  logic [31:0]           xe, ye, ze;
  point_t                pt_s1;
  point_t                pt_dly [PT_DLY];
  logic [F:0]            wx, wy, wz;
  logic [F:0]            wy_d [YD];
  logic [F:0]            wz_d [ZD];
  logic signed [F+2:0]   term [8];
  logic signed [F+2:0]   lx [4];
  logic signed [F+2:0]   ly [2];
  logic signed [F+2:0]   lz;
  logic signed [SW-1:0]  scaled;
  logic signed [gn3_pkg::OUT_W-1:0] noise_next;

  assign en       = !vld[LAT-1] || noise_ready;
  assign pt_ready = en;
  assign noise_valid = vld[LAT-1];

  assign xe = {{(32 - gn3_pkg::IN_W){x_coord[gn3_pkg::IN_W-1]}}, x_coord};
  assign ye = {{(32 - gn3_pkg::IN_W){y_coord[gn3_pkg::IN_W-1]}}, y_coord};
  assign ze = {{(32 - gn3_pkg::IN_W){z_coord[gn3_pkg::IN_W-1]}}, z_coord};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pt_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_s1.cx <= xe[F+7:F];
      pt_s1.cy <= ye[F+7:F];
      pt_s1.cz <= ze[F+7:F];
      pt_s1.dx <= xe[F-1:0];
      pt_s1.dy <= ye[F-1:0];
      pt_s1.dz <= ze[F-1:0];
      pt_dly[0] <= pt_s1;
      for (int i = 1; i < PT_DLY; i++) begin
        pt_dly[i] <= pt_dly[i-1];
      end
      wy_d[0] <= wy;
      for (int i = 1; i < YD; i++) begin
        wy_d[i] <= wy_d[i-1];
      end
      wz_d[0] <= wz;
      for (int i = 1; i < ZD; i++) begin
        wz_d[i] <= wz_d[i-1];
      end
      noise_value <= noise_next;
    end
  end

  gn3_fade #(.FRAC_BITS(F)) u_fade_x (.clk(clk), .en(en), .t(pt_s1.dx), .w(wx));
  gn3_fade #(.FRAC_BITS(F)) u_fade_y (.clk(clk), .en(en), .t(pt_s1.dy), .w(wy));
  gn3_fade #(.FRAC_BITS(F)) u_fade_z (.clk(clk), .en(en), .t(pt_s1.dz), .w(wz));

  gn3_hash #(.FRAC_BITS(F)) u_hash (
    .clk  (clk),
    .en   (en),
    .cx   (pt_dly[PT_DLY-1].cx),
    .cy   (pt_dly[PT_DLY-1].cy),
    .cz   (pt_dly[PT_DLY-1].cz),
    .dx   (pt_dly[PT_DLY-1].dx),
    .dy   (pt_dly[PT_DLY-1].dy),
    .dz   (pt_dly[PT_DLY-1].dz),
    .term (term)
  );

  for (genvar g = 0; g < 4; g++) begin : g_lerp_x
    gn3_lerp #(.FRAC_BITS(F)) u_lerp (
      .clk(clk), .en(en), .p(term[2*g]), .q(term[2*g+1]), .w(wx), .r(lx[g])
    );
  end

  for (genvar g = 0; g < 2; g++) begin : g_lerp_y
    gn3_lerp #(.FRAC_BITS(F)) u_lerp (
      .clk(clk), .en(en), .p(lx[2*g]), .q(lx[2*g+1]), .w(wy_d[YD-1]), .r(ly[g])
    );
  end

  gn3_lerp #(.FRAC_BITS(F)) u_lerp_z (
    .clk(clk), .en(en), .p(ly[0]), .q(ly[1]), .w(wz_d[ZD-1]), .r(lz)
  );

  if (F > gn3_pkg::OUT_FRAC) begin : g_round
    localparam int SH = F - gn3_pkg::OUT_FRAC;
    localparam logic signed [F+3:0] OUT_HALF = (F+4)'(1) << (SH - 1);
    logic signed [F+3:0] rsum;
    assign rsum   = (F+4)'(lz) + OUT_HALF;
    assign scaled = SW'(rsum >>> SH);
  end else begin : g_scale
    assign scaled = SW'(lz) <<< (gn3_pkg::OUT_FRAC - F);
  end

  always_comb begin
    if (scaled > gn3_pkg::OUT_MAX) begin
      noise_next = gn3_pkg::OUT_MAX;
    end else if (scaled < gn3_pkg::OUT_MIN) begin
      noise_next = gn3_pkg::OUT_MIN;
    end else begin
      noise_next = scaled[gn3_pkg::OUT_W-1:0];
    end
  end

  a_empty_slot: assert property (@(posedge clk) disable iff (rst)
    pt_ready && !pt_valid |=> !vld[0])
    else $error("empty request slot entered the pipeline");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    pt_ready && vld[LAT-2] |=> noise_valid)
    else $error("request lost before the result register");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !pt_ready |=> $stable(vld))
    else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

// ===== design/gn3_fade.sv =====
// ----------------------------------------------------------------------------
// gn3_fade
// Pipelined fade curve 6t^5 - 15t^4 + 10t^3 by Horner's rule, at most one
// multiply per stage, clamped to [0, 1].
// ----------------------------------------------------------------------------
`default_nettype none

module gn3_fade #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS-1:0] t,
  output logic [FRAC_BITS:0]   w
);

  localparam int F  = FRAC_BITS;
  localparam int VW = F + 5;
  localparam int PW = 2 * F + 6;
  localparam int TD = gn3_pkg::FADE_LAT - 2;

  localparam logic signed [VW-1:0] FIFTEEN  = VW'(15) << F;
  localparam logic signed [PW-1:0] HALF     = PW'(1) << (F - 1);
  localparam logic signed [PW-1:0] TEN_RND  = (PW'(10) << (2 * F)) + HALF;
  localparam logic signed [VW-1:0] ONE      = VW'(1) << F;

  logic [F-1:0]           tp [TD];
  logic signed [VW-1:0]   t_ext;
  logic signed [VW-1:0]   a, b, c, d;
  logic signed [PW-1:0]   p1, p2, p3, p4;
  logic signed [VW-1:0]   w_raw;

  assign t_ext = VW'(t);
  assign w_raw = VW'((p4 + HALF) >>> F);

  always_ff @(posedge clk) begin
    if (en) begin
      tp[0] <= t;
      for (int i = 1; i < TD; i++) begin
        tp[i] <= tp[i-1];
      end
      a  <= (t_ext <<< 2) + (t_ext <<< 1) - FIFTEEN;
      p1 <= a * $signed({1'b0, tp[0]});
      b  <= VW'((p1 + TEN_RND) >>> F);
      p2 <= b * $signed({1'b0, tp[2]});
      c  <= VW'((p2 + HALF) >>> F);
      p3 <= c * $signed({1'b0, tp[4]});
      d  <= VW'((p3 + HALF) >>> F);
      p4 <= d * $signed({1'b0, tp[6]});
      if (w_raw < 0) begin
        w <= '0;
      end else if (w_raw > ONE) begin
        w <= (F+1)'(ONE);
      end else begin
        w <= (F+1)'(w_raw);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/gn3_hash.sv =====
// ----------------------------------------------------------------------------
// gn3_hash
// Corner hashing through the permutation table (one lookup level per stage)
// and the gradient dot term of each of the eight cell corners.
// ----------------------------------------------------------------------------
`default_nettype none

module gn3_hash #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [7:0]                  cx,
  input  logic [7:0]                  cy,
  input  logic [7:0]                  cz,
  input  logic [FRAC_BITS-1:0]        dx,
  input  logic [FRAC_BITS-1:0]        dy,
  input  logic [FRAC_BITS-1:0]        dz,
  output logic signed [FRAC_BITS+2:0] term [8]
);

  localparam int F  = FRAC_BITS;
  localparam int OW = F + 2;

  localparam logic signed [OW-1:0] ONE = OW'(1) << F;

  logic [7:0]   hx  [2];
  logic [7:0]   hxy [4];
  logic [3:0]   hc  [8];
  logic [7:0]   cy_a, cz_a, cz_b;
  logic [F-1:0] dx_d [3];
  logic [F-1:0] dy_d [3];
  logic [F-1:0] dz_d [3];

  logic signed [OW-1:0]  ox0, ox1, oy0, oy1, oz0, oz1;
  logic signed [OW-1:0]  ox, oy, oz, u, v;
  logic signed [F+2:0]   term_next [8];
  logic                  sel_x, sel_y;
  logic [3:0]            h;

  always_ff @(posedge clk) begin
    if (en) begin
      hx[0] <= gn3_pkg::perm(cx);
      hx[1] <= gn3_pkg::perm(cx + 8'd1);
      cy_a  <= cy;
      cz_a  <= cz;
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 2; i++) begin
          hxy[i + 2*j] <= gn3_pkg::perm(hx[i] + cy_a + 8'(j));
        end
      end
      cz_b <= cz_a;
      for (int k = 0; k < 2; k++) begin
        for (int m = 0; m < 4; m++) begin
          hc[m + 4*k] <= 4'(gn3_pkg::perm(hxy[m] + cz_b + 8'(k)));
        end
      end
      dx_d[0] <= dx;
      dy_d[0] <= dy;
      dz_d[0] <= dz;
      for (int s = 1; s < 3; s++) begin
        dx_d[s] <= dx_d[s-1];
        dy_d[s] <= dy_d[s-1];
        dz_d[s] <= dz_d[s-1];
      end
      term <= term_next;
    end
  end

  assign ox0 = OW'(dx_d[2]);
  assign oy0 = OW'(dy_d[2]);
  assign oz0 = OW'(dz_d[2]);
  assign ox1 = ox0 - ONE;
  assign oy1 = oy0 - ONE;
  assign oz1 = oz0 - ONE;

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      h  = hc[c];
      ox = ((c & 1) != 0) ? ox1 : ox0;
      oy = ((c & 2) != 0) ? oy1 : oy0;
      oz = ((c & 4) != 0) ? oz1 : oz0;
      sel_x = !h[3] || h == gn3_pkg::GRAD_XY_POS || h == gn3_pkg::GRAD_XY_NEG;
      sel_y = h[3:2] == 2'b00 || h == gn3_pkg::GRAD_XY_POS
              || h == gn3_pkg::GRAD_XY_NEG;
      u = sel_x ? ox : oy;
      v = sel_y ? oy : oz;
      term_next[c] = (h[0] ? -(F+3)'(u) : (F+3)'(u))
                   + (h[1] ? -(F+3)'(v) : (F+3)'(v));
    end
  end

endmodule

`default_nettype wire

// ===== design/gn3_lerp.sv =====
// ----------------------------------------------------------------------------
// gn3_lerp
// Three-stage linear blend p + round(w * (q - p)): difference, product,
// rounding add.
// ----------------------------------------------------------------------------
`default_nettype none

module gn3_lerp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [FRAC_BITS+2:0] p,
  input  logic signed [FRAC_BITS+2:0] q,
  input  logic [FRAC_BITS:0]          w,
  output logic signed [FRAC_BITS+2:0] r
);

  localparam int F  = FRAC_BITS;
  localparam int DW = F + 4;
  localparam int PW = 2 * F + 6;

  localparam logic signed [PW-1:0] HALF = PW'(1) << (F - 1);

  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod;
  logic signed [F+2:0]  p1, p2;
  logic [F:0]           w1;

  always_ff @(posedge clk) begin
    if (en) begin
      diff <= DW'(q) - DW'(p);
      p1   <= p;
      w1   <= w;
      prod <= diff * $signed({1'b0, w1});
      p2   <= p1;
      r    <= p2 + (F+3)'((prod + HALF) >>> F);
    end
  end

endmodule

`default_nettype wire
